[sv/dead_reckoning_pose_integrator_core_macros.svh]
// Assertion helpers shared by the pose integrator.
`ifndef DEAD_RECKONING_POSE_INTEGRATOR_CORE_MACROS_SVH
`define DEAD_RECKONING_POSE_INTEGRATOR_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define DRPI_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define DRPI_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[sv/drpi_pkg.sv]
package drpi_pkg;

   localparam int ITER_W = 5;

   localparam logic signed [8:0] KEY_LEFT    = 9'sd81;
   localparam logic signed [8:0] KEY_FORWARD = 9'sd82;
   localparam logic signed [8:0] KEY_RIGHT   = 9'sd83;
   localparam logic signed [8:0] KEY_BACK    = 9'sd84;
   localparam logic signed [8:0] KEY_STOP    = -9'sd1;

   localparam logic [2:0] REG_FORWARD_SPEED = 3'd0;
   localparam logic [2:0] REG_TURN_RATE     = 3'd1;
   localparam logic [2:0] REG_START_X       = 3'd2;
   localparam logic [2:0] REG_START_Y       = 3'd3;
   localparam logic [2:0] REG_START_HEADING = 3'd4;

   localparam logic signed [18:0] PI_Q13      = 19'sd25736;
   localparam logic signed [18:0] TWO_PI_Q13  = 19'sd51472;
   localparam logic signed [18:0] HALF_PI_Q14 = 19'sd25736;
   localparam logic signed [18:0] PI_Q14      = 19'sd51472;
   localparam logic signed [32:0] GAIN_Q30    = 33'sd652032874;

   // floor(v/5) for v below 2^18, floor(t/9) for t below 2^27
   localparam logic [16:0] RECIP5 = 17'd52429;
   localparam logic [23:0] RECIP9 = 24'd14913081;
   localparam logic [47:0] HALF_DEN = 48'd75497472;

   typedef enum logic [3:0] {
      ST_IDLE, ST_DECODE, ST_STEP, ST_HEAD, ST_ROT, ST_MUL, ST_DIV, ST_ACC, ST_DONE
   } state_type;

   typedef struct packed {
      logic              capture;
      logic              decode;
      logic              step;
      logic              head;
      logic              rot;
      logic [ITER_W-1:0] iter;
      logic              mul;
      logic              div;
      logic              acc;
      logic              publish;
   } drpi_cmd_type;

   typedef struct packed {
      logic load;
      logic out_busy;
   } drpi_sts_type;

   function automatic logic [31:0] atan_q30(input logic [ITER_W-1:0] i);
      logic [31:0] r;
      unique case (i)
         5'd0:  r = 32'd843314857;
         5'd1:  r = 32'd497837829;
         5'd2:  r = 32'd263043837;
         5'd3:  r = 32'd133525159;
         5'd4:  r = 32'd67021687;
         5'd5:  r = 32'd33543516;
         5'd6:  r = 32'd16775851;
         5'd7:  r = 32'd8388437;
         5'd8:  r = 32'd4194283;
         5'd9:  r = 32'd2097149;
         5'd10: r = 32'd1048576;
         5'd11: r = 32'd524288;
         5'd12: r = 32'd262144;
         5'd13: r = 32'd131072;
         5'd14: r = 32'd65536;
         5'd15: r = 32'd32768;
         5'd16: r = 32'd16384;
         5'd17: r = 32'd8192;
         5'd18: r = 32'd4096;
         5'd19: r = 32'd2048;
         5'd20: r = 32'd1024;
         5'd21: r = 32'd512;
         5'd22: r = 32'd256;
         5'd23: r = 32'd128;
         default: r = 32'd0;
      endcase
      return r;
   endfunction

endpackage

[sv/drpi_if.sv]
interface drpi_req_if;
   logic              valid;
   logic              ready;
   logic signed [8:0] key_code;
   logic              load_start;
   modport source (output valid, key_code, load_start, input ready);
   modport sink (input valid, key_code, load_start, output ready);
endinterface

interface drpi_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] pos_x;
   logic signed [31:0] pos_y;
   logic signed [15:0] heading;
   modport source (output valid, pos_x, pos_y, heading, input ready);
   modport sink (input valid, pos_x, pos_y, heading, output ready);
endinterface

interface drpi_csr_if;
   logic        valid;
   logic        ready;
   logic [2:0]  index;
   logic [31:0] data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

[sv/dead_reckoning_pose_integrator_core.sv]
// Dead-reckoning pose integrator.
// req_ch takes one transaction per 0.1 s tick: a key code and a load flag.
// rsp_ch returns one transaction per request: x, y (Q16.16) and heading (Q3.13).
// csr_ch writes speed, turn rate and the start pose; it is always ready and
// must only be written while no request is in flight.
// An integrating tick runs through the CORDIC rotator, which does one
// rotation per cycle, followed by multiply, divide-by-nine and accumulate steps.
// A load tick skips the rotation steps and publishes the start pose.
// One request is worked at a time; req_ch.ready is high only while idle, so
// a new tick waits until the controller has published the last result.
// The result sits in an output register, so a new request is accepted while
// an earlier result waits; a stalled rsp_ch holds the next result in the
// controller until the register frees up.
// Reset clears the pose, speed, turn rate and all configuration registers.
`include "dead_reckoning_pose_integrator_core_macros.svh"
module dead_reckoning_pose_integrator_core #(
   parameter int CORDIC_STEPS = 16,
   parameter int POS_WIDTH    = 32
) (
   input logic        clock,
   input logic        reset,
   drpi_req_if.sink   req_ch,
   drpi_rsp_if.source rsp_ch,
   drpi_csr_if.sink   csr_ch
);
   import drpi_pkg::*;

   drpi_cmd_type cmd;
   drpi_sts_type sts;

   assign csr_ch.ready = 1'b1;

   drpi_ctrl #(.CORDIC_STEPS(CORDIC_STEPS)) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   drpi_datapath #(.POS_WIDTH(POS_WIDTH)) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .sts         (sts),
      .key_code    (req_ch.key_code),
      .load_start  (req_ch.load_start),
      .csr_valid   (csr_ch.valid),
      .csr_index   (csr_ch.index),
      .csr_data    (csr_ch.data),
      .rsp_valid   (rsp_ch.valid),
      .rsp_ready   (rsp_ch.ready),
      .rsp_pos_x   (rsp_ch.pos_x),
      .rsp_pos_y   (rsp_ch.pos_y),
      .rsp_heading (rsp_ch.heading)
   );

   `DRPI_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_ch.valid && req_ch.ready, !req_ch.ready, "request accepted while busy")
   `DRPI_ASSERT_NOW(a_heading_range, clock, reset, rsp_ch.valid, (rsp_ch.heading <= 16'sd25736) && (rsp_ch.heading >= -16'sd25736), "heading outside plus or minus pi")
   `DRPI_ASSERT_NOW(a_publish_free, clock, reset, cmd.publish, !sts.out_busy, "result overwritten while stalled")

endmodule

[sv/drpi_ctrl.sv]
module drpi_ctrl #(
   parameter int CORDIC_STEPS = 16
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  drpi_pkg::drpi_sts_type     sts,
   output drpi_pkg::drpi_cmd_type     cmd
);
   import drpi_pkg::*;

   localparam int IW = $clog2(CORDIC_STEPS);

   state_type       state_ff, state_in;
   logic [IW-1:0]   iter_ff, iter_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         iter_ff  <= '0;
      end else begin
         state_ff <= state_in;
         iter_ff  <= iter_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      iter_in   = iter_ff;
      cmd       = '0;
      cmd.iter  = ITER_W'(iter_ff);
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready   = 1'b1;
            cmd.capture = req_valid;
            if (req_valid) state_in = ST_DECODE;
         end
         ST_DECODE: begin
            cmd.decode = 1'b1;
            state_in   = sts.load ? ST_DONE : ST_STEP;
         end
         ST_STEP: begin
            cmd.step = 1'b1;
            state_in = ST_HEAD;
         end
         ST_HEAD: begin
            cmd.head = 1'b1;
            iter_in  = '0;
            state_in = ST_ROT;
         end
         ST_ROT: begin
            cmd.rot = 1'b1;
            iter_in = iter_ff + 1'b1;
            if (iter_ff == IW'(CORDIC_STEPS - 1)) state_in = ST_MUL;
         end
         ST_MUL: begin
            cmd.mul  = 1'b1;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            cmd.div  = 1'b1;
            state_in = ST_ACC;
         end
         ST_ACC: begin
            cmd.acc  = 1'b1;
            state_in = ST_DONE;
         end
         ST_DONE: begin
            // hold until the output register is free
            if (!sts.out_busy) begin
               cmd.publish = 1'b1;
               state_in    = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

endmodule

[sv/drpi_datapath.sv]
module drpi_datapath #(
   parameter int POS_WIDTH = 32
) (
   input  logic                   clock,
   input  logic                   reset,
   input  drpi_pkg::drpi_cmd_type cmd,
   output drpi_pkg::drpi_sts_type sts,
   input  logic signed [8:0]      key_code,
   input  logic                   load_start,
   input  logic                   csr_valid,
   input  logic [2:0]             csr_index,
   input  logic [31:0]            csr_data,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic signed [31:0]     rsp_pos_x,
   output logic signed [31:0]     rsp_pos_y,
   output logic signed [15:0]     rsp_heading
);
   import drpi_pkg::*;

   localparam int SW = ((POS_WIDTH > 32) ? POS_WIDTH : 32) + 1;
   localparam logic signed [SW-1:0] P_MAX = (SW'(1) <<< (POS_WIDTH - 1)) - SW'(1);
   localparam logic signed [SW-1:0] P_MIN = -P_MAX - SW'(1);

   function automatic logic signed [POS_WIDTH-1:0] sat_pos(input logic signed [SW-1:0] v);
      logic signed [SW-1:0] r;
      priority if (v > P_MAX) r = P_MAX;
      else if (v < P_MIN)     r = P_MIN;
      else                    r = v;
      return r[POS_WIDTH-1:0];
   endfunction

   function automatic logic signed [18:0] wrap_pi(input logic signed [18:0] h);
      logic signed [18:0] r;
      priority if (h < -PI_Q13) r = h + TWO_PI_Q13;
      else if (h > PI_Q13)      r = h - TWO_PI_Q13;
      else                      r = h;
      return r;
   endfunction

   logic [15:0]                speed_cfg_ff, rate_cfg_ff;
   logic signed [31:0]         sx_cfg_ff, sy_cfg_ff;
   logic signed [15:0]         sh_cfg_ff;
   logic signed [8:0]          key_ff;
   logic                       load_ff;
   logic signed [16:0]         speed_ff, rate_ff;
   logic signed [POS_WIDTH-1:0] x_ff, y_ff;
   logic signed [15:0]         head_ff;
   logic signed [15:0]         step_ff;
   logic signed [32:0]         cx_ff, cy_ff;
   logic signed [33:0]         cz_ff;
   logic                       flip_ff;
   logic [47:0]                pc_ff, ps_ff;
   logic                       negc_ff, negs_ff;
   logic [21:0]                qc_ff, qs_ff;
   logic                       rsp_valid_ff;
   logic signed [31:0]         pos_x_ff, pos_y_ff;
   logic signed [15:0]         heading_ff;

   // heading step
   logic [16:0]        rate_mag;
   logic [16:0]        mag_p2;
   logic [33:0]        q5_prod;
   logic signed [15:0] step_in;
   // heading update and angle fold
   logic signed [18:0] hs, hn, ang, ang_f;
   logic               flip_in;
   logic signed [33:0] z_init;
   // rotation
   logic signed [32:0] dx, dy;
   logic signed [33:0] at;
   // displacement
   logic [15:0]        spd_mag;
   logic signed [32:0] cx_abs, cy_abs;
   logic [48:0]        tc_sum, ts_sum;
   logic [48:0]        qc_prod, qs_prod;
   logic signed [SW-1:0] disp_x, disp_y;
   logic signed [18:0] sh_wrap;

   assign rate_mag = rate_ff[16] ? 17'(-rate_ff) : 17'(rate_ff);
   assign mag_p2   = rate_mag + 17'd2;
   assign q5_prod  = mag_p2 * RECIP5;
   assign step_in  = rate_ff[16] ? -$signed({1'b0, q5_prod[32:18]})
                                 : $signed({1'b0, q5_prod[32:18]});

   assign hs = 19'(head_ff) + 19'(step_ff);
   assign hn = wrap_pi(hs);
   assign ang = (hn <<< 1) - 19'(step_ff);
   always_comb begin
      priority if (ang > HALF_PI_Q14) begin
         ang_f = ang - PI_Q14;  flip_in = 1'b1;
      end else if (ang < -HALF_PI_Q14) begin
         ang_f = ang + PI_Q14;  flip_in = 1'b1;
      end else begin
         ang_f = ang;           flip_in = 1'b0;
      end
   end
   assign z_init = {ang_f[16], ang_f[16:0], 16'b0};

   assign dx = cy_ff >>> cmd.iter;
   assign dy = cx_ff >>> cmd.iter;
   assign at = $signed({2'b00, atan_q30(cmd.iter)});

   assign spd_mag = speed_ff[16] ? 16'(-speed_ff) : 16'(speed_ff);
   assign cx_abs  = cx_ff[32] ? -cx_ff : cx_ff;
   assign cy_abs  = cy_ff[32] ? -cy_ff : cy_ff;

   assign tc_sum  = {1'b0, pc_ff} + {1'b0, HALF_DEN};
   assign ts_sum  = {1'b0, ps_ff} + {1'b0, HALF_DEN};
   assign qc_prod = tc_sum[48:24] * RECIP9;
   assign qs_prod = ts_sum[48:24] * RECIP9;

   assign disp_x = negc_ff ? -SW'($signed({1'b0, qc_ff})) : SW'($signed({1'b0, qc_ff}));
   assign disp_y = negs_ff ? -SW'($signed({1'b0, qs_ff})) : SW'($signed({1'b0, qs_ff}));

   assign sh_wrap = wrap_pi(19'(sh_cfg_ff));

   always_ff @(posedge clock) begin
      if (reset) begin
         speed_cfg_ff <= '0;
         rate_cfg_ff  <= '0;
         sx_cfg_ff    <= '0;
         sy_cfg_ff    <= '0;
         sh_cfg_ff    <= '0;
      end else if (csr_valid) begin
         unique case (csr_index)
            REG_FORWARD_SPEED: speed_cfg_ff <= csr_data[15:0];
            REG_TURN_RATE:     rate_cfg_ff  <= csr_data[15:0];
            REG_START_X:       sx_cfg_ff    <= csr_data;
            REG_START_Y:       sy_cfg_ff    <= csr_data;
            REG_START_HEADING: sh_cfg_ff    <= csr_data[15:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         speed_ff <= '0;
         rate_ff  <= '0;
         x_ff     <= '0;
         y_ff     <= '0;
         head_ff  <= '0;
      end else begin
         if (cmd.decode) begin
            if (load_ff) begin
               x_ff    <= sat_pos(SW'(sx_cfg_ff));
               y_ff    <= sat_pos(SW'(sy_cfg_ff));
               head_ff <= sh_wrap[15:0];
            end else begin
               unique case (key_ff)
                  KEY_LEFT:    rate_ff  <= -$signed({1'b0, rate_cfg_ff});
                  KEY_FORWARD: speed_ff <= $signed({1'b0, speed_cfg_ff});
                  KEY_RIGHT:   rate_ff  <= $signed({1'b0, rate_cfg_ff});
                  KEY_BACK:    speed_ff <= -$signed({1'b0, speed_cfg_ff});
                  KEY_STOP: begin
                     speed_ff <= '0;
                     rate_ff  <= '0;
                  end
                  default: ;
               endcase
            end
         end
         if (cmd.head) head_ff <= hn[15:0];
         if (cmd.acc) begin
            x_ff <= sat_pos(SW'(x_ff) + disp_x);
            y_ff <= sat_pos(SW'(y_ff) + disp_y);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         key_ff  <= key_code;
         load_ff <= load_start;
      end
      if (cmd.step) step_ff <= step_in;
      if (cmd.head) begin
         cx_ff   <= GAIN_Q30;
         cy_ff   <= '0;
         cz_ff   <= z_init;
         flip_ff <= flip_in;
      end
      if (cmd.rot) begin
         if (!cz_ff[33]) begin
            cx_ff <= cx_ff - dx;
            cy_ff <= cy_ff + dy;
            cz_ff <= cz_ff - at;
         end else begin
            cx_ff <= cx_ff + dx;
            cy_ff <= cy_ff - dy;
            cz_ff <= cz_ff + at;
         end
      end
      if (cmd.mul) begin
         pc_ff   <= spd_mag * cx_abs[31:0];
         ps_ff   <= spd_mag * cy_abs[31:0];
         negc_ff <= speed_ff[16] ^ flip_ff ^ cx_ff[32];
         negs_ff <= speed_ff[16] ^ flip_ff ^ cy_ff[32];
      end
      if (cmd.div) begin
         qc_ff <= qc_prod[48:27];
         qs_ff <= qs_prod[48:27];
      end
      if (cmd.publish) begin
         pos_x_ff   <= 32'(SW'(x_ff));
         pos_y_ff   <= 32'(SW'(y_ff));
         heading_ff <= head_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else if (cmd.publish) rsp_valid_ff <= 1'b1;
      else if (rsp_ready) rsp_valid_ff <= 1'b0;
   end

   assign sts.load     = load_ff;
   assign sts.out_busy = rsp_valid_ff && !rsp_ready;
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_pos_x    = pos_x_ff;
   assign rsp_pos_y    = pos_y_ff;
   assign rsp_heading  = heading_ff;

endmodule
